// File: rtl/plob_pkg.sv
// Package: shared types and constants of the price-level order book core.
package plob_pkg;

  localparam int unsigned MaxLevels = 64;
  localparam int unsigned IdxW      = $clog2(MaxLevels);
  localparam int unsigned CntW      = $clog2(MaxLevels + 1);
  localparam int unsigned PxW       = 24;
  localparam int unsigned SzW       = 32;
  localparam int unsigned SeqW      = 48;
  localparam int unsigned QtyW      = 40;
  localparam int unsigned ValW      = 62;
  localparam int unsigned UsedW     = 7;

  typedef enum logic [2:0] {
    KIND_UPDATE = 3'd0,
    KIND_CLEAR  = 3'd1,
    KIND_APPEND = 3'd2,
    KIND_DEPTH  = 3'd3,
    KIND_WALK   = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_SHIFT,
    ST_SHIFT_WAIT,
    ST_QUERY,
    ST_QUERY_WAIT,
    ST_DIV,
    ST_TOPS,
    ST_TOPS_WAIT,
    ST_OUT
  } state_e;

  // memory access from the control unit
  typedef struct packed {
    logic            rd_en;
    logic            rd_ask;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic            wr_ask;
    logic [IdxW-1:0] wr_addr;
    logic [PxW-1:0]  wr_px;
    logic [SzW-1:0]  wr_sz;
  } mem_req_t;

endpackage

// File: rtl/price_level_order_book_core.sv
// Top level: price-level order book core with stream ports.
//  channel | dir | fields
//  s_axis  | in  | kind, side, price, amount, incr, seq, level_count, want
//  m_axis  | out | status, tops, book_seq, quantity, value, lvls_taken
// One item at a time. Snapshot and rejected items go straight to the best bid and
// ask reads; the next request is taken only once the result has been accepted.
// Updates search linearly and then shift levels one place (one read, one write each).
// Depth and walk read the levels one at a time from the best; a walk ends in a division.
// Reset clears counts and book sequence; a stalled result holds the block.
module price_level_order_book_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // kind[2:0] side[4:3] price[29:5] amount[62:30] incr[63] seq[111:64]
  // level_count[119:112] want[151:120]
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[0] bid_valid[1] bid_price[25:2] bid_size[57:26] ask_valid[58]
  // ask_price[82:59] ask_size[114:83] book_seq[162:115] quantity[202:163]
  // value[264:203] lvls_taken[271:265]
  output logic [271:0] m_axis_tdata
);
  plob_pkg::mem_req_t mem_req;
  logic [plob_pkg::PxW-1:0] rd_px;
  logic [plob_pkg::SzW-1:0] rd_sz;
  logic div_start, div_done;
  logic [71:0] div_num, div_quo;
  logic [plob_pkg::QtyW-1:0] div_den;
  logic [271:0] out_data;

  plob_level_mem u_mem (.clk_i, .req_i(mem_req), .rd_px_o(rd_px), .rd_sz_o(rd_sz));

  plob_divider u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
    .den_i(div_den), .done_o(div_done), .quo_o(div_quo));

  plob_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .kind_i(s_axis_tdata[2:0]), .side_i(s_axis_tdata[4:3]),
    .price_i(s_axis_tdata[29:5]), .amount_i(s_axis_tdata[62:30]),
    .incr_i(s_axis_tdata[63]), .seq_i(s_axis_tdata[111:64]),
    .level_count_i(s_axis_tdata[119:112]), .want_i(s_axis_tdata[151:120]),
    .mem_req_o(mem_req), .rd_px_i(rd_px), .rd_sz_i(rd_sz),
    .div_start_o(div_start), .div_num_o(div_num), .div_den_o(div_den),
    .div_done_i(div_done), .div_quo_i(div_quo),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(out_data)
  );

  assign m_axis_tdata = out_data;
endmodule

// File: rtl/plob_level_mem.sv
// Level memory: bid and ask (price, size) tables, one write and one read port.
module plob_level_mem (
  input  logic                 clk_i,
  input  plob_pkg::mem_req_t   req_i,
  output logic [plob_pkg::PxW-1:0] rd_px_o,
  output logic [plob_pkg::SzW-1:0] rd_sz_o
);
  localparam int unsigned Depth = 2 * plob_pkg::MaxLevels;
  localparam int unsigned AW    = plob_pkg::IdxW + 1;

  logic [plob_pkg::PxW+plob_pkg::SzW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[{req_i.wr_ask, req_i.wr_addr}] <= {req_i.wr_px, req_i.wr_sz};
    end
    if (req_i.rd_en) begin
      {rd_px_o, rd_sz_o} <= mem[AW'({req_i.rd_ask, req_i.rd_addr})];
    end
  end
endmodule

// File: rtl/plob_divider.sv
// Divider: restoring radix-2 unsigned divide of the walk cost by the filled size.
module plob_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [71:0]               num_i,
  input  logic [plob_pkg::QtyW-1:0] den_i,
  output logic                      done_o,
  output logic [71:0]               quo_o
);
  logic [71:0]               quo_q, quo_d;
  logic [plob_pkg::QtyW:0]   rem_q, rem_d;
  logic [plob_pkg::QtyW-1:0] den_q;
  logic [6:0]                cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic [plob_pkg::QtyW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[plob_pkg::QtyW-1:0], quo_q[71]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = 7'd72;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[70:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d    = trial - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = busy_q && (cnt_q == 7'd1);
  assign quo_o  = quo_d;
endmodule

// File: rtl/plob_ctrl.sv
// Control: sequencer for updates, snapshots, depth queries and walks.
module plob_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               kind_i,
  input  logic [1:0]               side_i,
  input  logic [24:0]              price_i,
  input  logic [32:0]              amount_i,
  input  logic                     incr_i,
  input  logic [47:0]              seq_i,
  input  logic [7:0]               level_count_i,
  input  logic [31:0]              want_i,
  output plob_pkg::mem_req_t       mem_req_o,
  input  logic [plob_pkg::PxW-1:0] rd_px_i,
  input  logic [plob_pkg::SzW-1:0] rd_sz_i,
  output logic                     div_start_o,
  output logic [71:0]              div_num_o,
  output logic [plob_pkg::QtyW-1:0] div_den_o,
  input  logic                     div_done_i,
  input  logic [71:0]              div_quo_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [271:0]             out_data_o
);
  localparam int unsigned IW = plob_pkg::IdxW;
  localparam int unsigned CW = plob_pkg::CntW;
  localparam logic [CW-1:0] MaxCnt = CW'(plob_pkg::MaxLevels);
  localparam logic [plob_pkg::QtyW-1:0] QtyMax = '1;
  localparam logic [plob_pkg::ValW-1:0] ValMax = '1;

  plob_pkg::state_e state_q, state_d;

  logic [2:0]        kind_q, kind_d;
  logic              ask_q, ask_d;
  logic [23:0]       px_q, px_d;
  logic signed [33:0] amt_q, amt_d;
  logic              delta_q, delta_d;
  logic [47:0]       seq_q, seq_d;
  logic [CW-1:0]     lim_q, lim_d;
  logic [31:0]       want_q, want_d;
  logic [CW-1:0]     bid_n_q, bid_n_d, ask_n_q, ask_n_d;
  logic [47:0]       hseq_q, hseq_d;
  logic [CW-1:0]     k_q, k_d;        // walk position / step count
  logic [CW-1:0]     dst_q, dst_d;    // shift destination
  logic              ins_q, ins_d;    // shift direction: 1 open gap, 0 close gap
  logic              stat_q, stat_d;
  logic [plob_pkg::QtyW-1:0] qty_q, qty_d;
  logic [plob_pkg::ValW-1:0] val_q, val_d;
  logic [71:0]       cost_q, cost_d;
  logic [6:0]        used_q, used_d;
  logic [1:0]        top_q, top_d;    // 0 bid top requested, 1 ask top
  logic              bv_q, bv_d, av_q, av_d;
  logic [23:0]       bp_q, bp_d, ap_q, ap_d;
  logic [31:0]       bs_q, bs_d, as_q, as_d;
  logic              ov_q, ov_d;
  logic [63:0]       prod_q;
  logic              prod_v_q;

  logic [CW-1:0] n_cur;
  logic [CW-1:0] idx_k;
  logic signed [34:0] nxt;
  logic [31:0] clip;
  logic [31:0] rest, take;
  logic [plob_pkg::QtyW:0] qsum;
  logic [plob_pkg::ValW:0] vsum;
  logic [63:0] prod_d;
  logic prod_v_d;

  assign n_cur = ask_q ? ask_n_q : bid_n_q;
  // k-th level from best
  assign idx_k = ask_q ? k_q : (n_cur - CW'(1) - k_q);

  always_comb begin
    state_d = state_q;
    kind_d = kind_q; ask_d = ask_q; px_d = px_q; amt_d = amt_q; delta_d = delta_q;
    seq_d = seq_q; lim_d = lim_q; want_d = want_q;
    bid_n_d = bid_n_q; ask_n_d = ask_n_q; hseq_d = hseq_q;
    k_d = k_q; dst_d = dst_q; ins_d = ins_q; stat_d = stat_q;
    qty_d = qty_q; val_d = val_q; cost_d = cost_q; used_d = used_q;
    top_d = top_q; bv_d = bv_q; av_d = av_q; bp_d = bp_q; ap_d = ap_q;
    bs_d = bs_q; as_d = as_q; ov_d = ov_q;
    mem_req_o = '0;
    mem_req_o.rd_ask = ask_q;
    mem_req_o.wr_ask = ask_q;
    div_start_o = 1'b0;
    div_num_o = cost_q;
    div_den_o = qty_q;
    rest = want_q - qty_q[31:0];
    take = (rd_sz_i < rest) ? rd_sz_i : rest;
    prod_d = 64'(rd_px_i) * 64'(take);
    prod_v_d = 1'b0;
    nxt = '0;
    clip = '0;
    qsum = '0;
    vsum = '0;
    in_ready_o = (state_q == plob_pkg::ST_IDLE);
    unique case (state_q)
      plob_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          kind_d = kind_i; ask_d = (side_i != 2'd0); px_d = price_i[23:0];
          amt_d = 34'(signed'(amount_i)); delta_d = incr_i; seq_d = seq_i;
          lim_d = (level_count_i == 8'd0 || level_count_i > 8'(plob_pkg::MaxLevels)) ?
                  '1 : CW'(level_count_i);
          want_d = want_i;
          stat_d = 1'b0; qty_d = '0; val_d = '0; cost_d = '0; used_d = '0; k_d = '0;
          state_d = plob_pkg::ST_TOPS;
          priority case (kind_i)
            plob_pkg::KIND_UPDATE: begin
              if (price_i[24] || side_i[1]) stat_d = 1'b1;
              else state_d = plob_pkg::ST_SCAN;
            end
            plob_pkg::KIND_CLEAR: begin
              if (side_i == 2'd0) bid_n_d = '0; else ask_n_d = '0;
              if (seq_i > hseq_q) hseq_d = seq_i;
            end
            plob_pkg::KIND_APPEND: begin
              if (amount_i[32] || amount_i == '0) begin
                if (seq_i > hseq_q) hseq_d = seq_i;
              end else if (price_i[24] ||
                           ((side_i == 2'd0 ? bid_n_q : ask_n_q) >= MaxCnt)) begin
                stat_d = 1'b1;
              end else begin
                mem_req_o.wr_en = 1'b1;
                mem_req_o.wr_ask = (side_i != 2'd0);
                mem_req_o.wr_addr = IW'(side_i == 2'd0 ? bid_n_q : ask_n_q);
                mem_req_o.wr_px = price_i[23:0];
                mem_req_o.wr_sz = amount_i[31:0];
                if (side_i == 2'd0) bid_n_d = bid_n_q + CW'(1);
                else ask_n_d = ask_n_q + CW'(1);
                if (seq_i > hseq_q) hseq_d = seq_i;
              end
            end
            plob_pkg::KIND_DEPTH, plob_pkg::KIND_WALK: state_d = plob_pkg::ST_QUERY;
            default: stat_d = 1'b1;
          endcase
        end
      end
      // linear search for the first price not below px
      plob_pkg::ST_SCAN: begin
        if (k_q >= n_cur) begin
          if (amt_q <= 0) begin
            if (seq_q > hseq_q) hseq_d = seq_q;
            state_d = plob_pkg::ST_TOPS;
          end else if (n_cur >= MaxCnt) begin
            stat_d = 1'b1; state_d = plob_pkg::ST_TOPS;
          end else begin
            mem_req_o.wr_en = 1'b1; mem_req_o.wr_addr = IW'(k_q);
            mem_req_o.wr_px = px_q;
            mem_req_o.wr_sz = amt_q[32] ? 32'hFFFF_FFFF : amt_q[31:0];
            if (ask_q) ask_n_d = ask_n_q + CW'(1); else bid_n_d = bid_n_q + CW'(1);
            if (seq_q > hseq_q) hseq_d = seq_q;
            state_d = plob_pkg::ST_TOPS;
          end
        end else begin
          mem_req_o.rd_en = 1'b1; mem_req_o.rd_addr = IW'(k_q);
          state_d = plob_pkg::ST_SCAN_WAIT;
        end
      end
      plob_pkg::ST_SCAN_WAIT: begin
        if (rd_px_i < px_q) begin
          k_d = k_q + CW'(1); state_d = plob_pkg::ST_SCAN;
        end else if (rd_px_i == px_q) begin
          nxt = delta_q ? (35'(rd_sz_i) + 35'(amt_q)) : 35'(amt_q);
          if (seq_q > hseq_q) hseq_d = seq_q;
          if (nxt <= 0) begin
            ins_d = 1'b0; dst_d = k_q; state_d = plob_pkg::ST_SHIFT;
            if (ask_q) ask_n_d = ask_n_q - CW'(1); else bid_n_d = bid_n_q - CW'(1);
          end else begin
            clip = (nxt > 35'sh0FFFF_FFFF) ? 32'hFFFF_FFFF : nxt[31:0];
            mem_req_o.wr_en = 1'b1; mem_req_o.wr_addr = IW'(k_q);
            mem_req_o.wr_px = px_q; mem_req_o.wr_sz = clip;
            state_d = plob_pkg::ST_TOPS;
          end
        end else begin
          if (amt_q <= 0) begin
            if (seq_q > hseq_q) hseq_d = seq_q;
            state_d = plob_pkg::ST_TOPS;
          end else if (n_cur >= MaxCnt) begin
            stat_d = 1'b1; state_d = plob_pkg::ST_TOPS;
          end else begin
            ins_d = 1'b1; dst_d = n_cur; state_d = plob_pkg::ST_SHIFT;
            if (seq_q > hseq_q) hseq_d = seq_q;
          end
        end
      end
      // move entries one place, one read and then one write per moved entry
      plob_pkg::ST_SHIFT: begin
        if (ins_q && dst_q == k_q) begin
          mem_req_o.wr_en = 1'b1; mem_req_o.wr_addr = IW'(k_q);
          mem_req_o.wr_px = px_q;
          mem_req_o.wr_sz = amt_q[32] ? 32'hFFFF_FFFF : amt_q[31:0];
          if (ask_q) ask_n_d = ask_n_q + CW'(1); else bid_n_d = bid_n_q + CW'(1);
          state_d = plob_pkg::ST_TOPS;
        end else if (!ins_q && dst_q >= n_cur) begin
          state_d = plob_pkg::ST_TOPS;
        end else begin
          mem_req_o.rd_en = 1'b1;
          mem_req_o.rd_addr = ins_q ? IW'(dst_q - CW'(1)) : IW'(dst_q + CW'(1));
          state_d = plob_pkg::ST_SHIFT_WAIT;
        end
      end
      plob_pkg::ST_SHIFT_WAIT: begin
        mem_req_o.wr_en = 1'b1; mem_req_o.wr_addr = IW'(dst_q);
        mem_req_o.wr_px = rd_px_i; mem_req_o.wr_sz = rd_sz_i;
        dst_d = ins_q ? dst_q - CW'(1) : dst_q + CW'(1);
        state_d = plob_pkg::ST_SHIFT;
      end
      plob_pkg::ST_QUERY: begin
        // fold in the product registered in ST_QUERY_WAIT
        if (prod_v_q) begin
          vsum = {1'b0, val_q} + (plob_pkg::ValW+1)'(prod_q);
          if (kind_q == plob_pkg::KIND_DEPTH)
            val_d = vsum[plob_pkg::ValW] ? ValMax : vsum[plob_pkg::ValW-1:0];
          else cost_d = cost_q + 72'(prod_q);
        end
        if (k_q >= n_cur || k_q >= lim_q && kind_q == plob_pkg::KIND_DEPTH ||
            kind_q == plob_pkg::KIND_WALK && qty_q[31:0] >= want_q) begin
          if (kind_q == plob_pkg::KIND_WALK && qty_q != '0) begin
            div_start_o = 1'b1;
            div_num_o = prod_v_q ? cost_q + 72'(prod_q) : cost_q;
            state_d = plob_pkg::ST_DIV;
          end else state_d = plob_pkg::ST_TOPS;
        end else begin
          mem_req_o.rd_en = 1'b1; mem_req_o.rd_addr = IW'(idx_k);
          state_d = plob_pkg::ST_QUERY_WAIT;
        end
      end
      plob_pkg::ST_QUERY_WAIT: begin
        k_d = k_q + CW'(1);
        prod_v_d = 1'b1;
        if (kind_q == plob_pkg::KIND_DEPTH) begin
          prod_d = 64'(rd_px_i) * 64'(rd_sz_i);
          qsum = {1'b0, qty_q} + (plob_pkg::QtyW+1)'(rd_sz_i);
          qty_d = qsum[plob_pkg::QtyW] ? QtyMax : qsum[plob_pkg::QtyW-1:0];
        end else begin
          qty_d = qty_q + plob_pkg::QtyW'(take);
          used_d = used_q + 7'd1;
        end
        state_d = plob_pkg::ST_QUERY;
      end
      plob_pkg::ST_DIV: begin
        if (div_done_i) begin
          val_d = div_quo_i[plob_pkg::ValW-1:0];
          state_d = plob_pkg::ST_TOPS;
        end
      end
      // fetch best bid, then best ask
      plob_pkg::ST_TOPS: begin
        mem_req_o.rd_en = 1'b1;
        if (top_q == 2'd0) begin
          mem_req_o.rd_ask = 1'b0; mem_req_o.rd_addr = IW'(bid_n_q - CW'(1));
        end else begin
          mem_req_o.rd_ask = 1'b1; mem_req_o.rd_addr = '0;
        end
        state_d = plob_pkg::ST_TOPS_WAIT;
      end
      plob_pkg::ST_TOPS_WAIT: begin
        if (top_q == 2'd0) begin
          bv_d = (bid_n_q != '0);
          bp_d = bv_d ? rd_px_i : '0; bs_d = bv_d ? rd_sz_i : '0;
          top_d = 2'd1; state_d = plob_pkg::ST_TOPS;
        end else begin
          av_d = (ask_n_q != '0);
          ap_d = av_d ? rd_px_i : '0; as_d = av_d ? rd_sz_i : '0;
          top_d = 2'd0; ov_d = 1'b1; state_d = plob_pkg::ST_OUT;
        end
      end
      plob_pkg::ST_OUT: begin
        if (out_ready_i) begin
          ov_d = 1'b0; state_d = plob_pkg::ST_IDLE;
        end
      end
      default: state_d = plob_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plob_pkg::ST_IDLE;
      bid_n_q <= '0; ask_n_q <= '0; hseq_q <= '0;
      ov_q <= 1'b0; top_q <= '0; prod_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bid_n_q <= bid_n_d; ask_n_q <= ask_n_d; hseq_q <= hseq_d;
      ov_q <= ov_d; top_q <= top_d;
      prod_v_q <= prod_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; ask_q <= ask_d; px_q <= px_d; amt_q <= amt_d; delta_q <= delta_d;
    seq_q <= seq_d; lim_q <= lim_d; want_q <= want_d;
    k_q <= k_d; dst_q <= dst_d; ins_q <= ins_d; stat_q <= stat_d;
    qty_q <= qty_d; val_q <= val_d; cost_q <= cost_d; used_q <= used_d;
    bv_q <= bv_d; av_q <= av_d; bp_q <= bp_d; ap_q <= ap_d; bs_q <= bs_d; as_q <= as_d;
    prod_q <= prod_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o = {used_q, val_q, qty_q, hseq_q, as_q, ap_q, av_q,
                       bs_q, bp_q, bv_q, stat_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bid_n_q <= MaxCnt && ask_n_q <= MaxCnt)
    else $error("level count above table size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !ov_q)
    else $error("input taken while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hseq_q >= $past(hseq_q))
    else $error("sequence went backward");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == plob_pkg::ST_DIV) |-> (qty_q != '0))
    else $error("divide by zero");
endmodule
